FILE: sv/raft_es_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raft_es_pkg
// Shared types and codes for the raft election state block.
// ----------------------------------------------------------------------------
`default_nettype none

package raft_es_pkg;

  localparam int ID_BITS    = 4;
  localparam int FTERM_BITS = 32;
  localparam int CNT_BITS   = 5;
  localparam int MODE_BITS  = 3;
  localparam int ROLE_BITS  = 2;

  localparam logic [MODE_BITS-1:0] MODE_LOAD      = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_CANDIDATE = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FOLLOWER  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_LEADER    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_GRANT     = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_RECORD    = 3'd5;

  localparam logic [ROLE_BITS-1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [ROLE_BITS-1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [ROLE_BITS-1:0] ROLE_LEADER    = 2'd2;

  typedef struct packed {
    logic [ROLE_BITS-1:0]  role;
    logic [FTERM_BITS-1:0] term;
    logic                  vote_held;
    logic [ID_BITS-1:0]    vote_target;
    logic [CNT_BITS-1:0]   votes_granted;
    logic                  ok;
    logic                  fault;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/raft_es_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raft_es_update
// Next-state and result logic for one election event.
// ----------------------------------------------------------------------------
`default_nettype none

module raft_es_update
  import raft_es_pkg::*;
#(
  parameter int MAX_REPLICAS = 16,
  parameter int TERM_BITS    = 32
) (
  input  wire logic [MODE_BITS-1:0]  mode,
  input  wire logic [FTERM_BITS-1:0] term_in,
  input  wire logic [ID_BITS-1:0]    peer,
  input  wire logic                  peer_present,
  input  wire logic [ID_BITS-1:0]    self_id,
  input  wire logic [ROLE_BITS-1:0]  role_cur,
  input  wire logic [TERM_BITS-1:0]  term_cur,
  input  wire logic                  vv_cur,
  input  wire logic [ID_BITS-1:0]    vid_cur,
  input  wire logic [((MAX_REPLICAS < (1 << ID_BITS)) ? MAX_REPLICAS : (1 << ID_BITS))-1:0]
                                     bits_cur,
  input  wire logic [CNT_BITS-1:0]   cnt_cur,
  output logic      [ROLE_BITS-1:0]  role_next,
  output logic      [TERM_BITS-1:0]  term_next,
  output logic                       vv_next,
  output logic      [ID_BITS-1:0]    vid_next,
  output logic [((MAX_REPLICAS < (1 << ID_BITS)) ? MAX_REPLICAS : (1 << ID_BITS))-1:0]
                                     bits_next,
  output logic      [CNT_BITS-1:0]   cnt_next,
  output res_t                       res
);

  localparam int VW = (MAX_REPLICAS < (1 << ID_BITS)) ? MAX_REPLICAS : (1 << ID_BITS);
  localparam int XW = (TERM_BITS > FTERM_BITS) ? TERM_BITS : FTERM_BITS;

  logic [VW-1:0]        peer_hot;
  logic [VW-1:0]        self_hot;
  logic [XW-1:0]        term_in_x;
  logic [XW-1:0]        term_out_x;
  logic [TERM_BITS-1:0] term_ext;
  logic                 ok;
  logic                 fault;

  // one-hot ids; ids at or beyond the replica count decode to nothing
  always_comb begin
    for (int i = 0; i < VW; i++) begin
      peer_hot[i] = (peer == ID_BITS'(i));
      self_hot[i] = (self_id == ID_BITS'(i));
    end
  end

  assign term_in_x = XW'(term_in);
  assign term_ext  = term_in_x[TERM_BITS-1:0];

  always_comb begin
    role_next = role_cur;
    term_next = term_cur;
    vv_next   = vv_cur;
    vid_next  = vid_cur;
    bits_next = bits_cur;
    cnt_next  = cnt_cur;
    ok        = 1'b0;
    fault     = 1'b0;
    unique case (mode)
      MODE_LOAD: begin
        term_next = term_ext;
        vv_next   = peer_present;
        vid_next  = peer_present ? peer : '0;
      end
      MODE_CANDIDATE: begin
        role_next = ROLE_CANDIDATE;
        if (&term_cur) begin
          fault = 1'b1;
        end else begin
          term_next = term_cur + TERM_BITS'(1);
        end
        vv_next   = 1'b1;
        vid_next  = self_id;
        bits_next = self_hot;
        cnt_next  = CNT_BITS'(|self_hot);
      end
      MODE_FOLLOWER: begin
        if (term_ext < term_cur) begin
          fault = 1'b1;
        end else begin
          role_next = ROLE_FOLLOWER;
          bits_next = '0;
          cnt_next  = '0;
          if (term_ext != term_cur) begin
            term_next = term_ext;
            vv_next   = 1'b0;
            vid_next  = '0;
            ok        = 1'b1;
          end
        end
      end
      MODE_LEADER: begin
        role_next = ROLE_LEADER;
        bits_next = '0;
        cnt_next  = '0;
      end
      MODE_GRANT: begin
        if ((|peer_hot) && (!vv_cur || vid_cur == peer)) begin
          vv_next  = 1'b1;
          vid_next = peer;
          ok       = 1'b1;
        end
      end
      MODE_RECORD: begin
        if ((|peer_hot) && !(|(bits_cur & peer_hot))) begin
          bits_next = bits_cur | peer_hot;
          cnt_next  = cnt_cur + CNT_BITS'(1);
          ok        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign term_out_x = XW'(term_next);

  always_comb begin
    res.role          = role_next;
    res.term          = term_out_x[FTERM_BITS-1:0];
    res.vote_held     = vv_next;
    res.vote_target   = vv_next ? vid_next : '0;
    res.votes_granted = cnt_next;
    res.ok            = ok;
    res.fault         = fault;
  end

endmodule

`default_nettype wire

FILE: sv/raft_election_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raft_election_state
// Election state of one replica: role, term, vote and granted voters.
// ----------------------------------------------------------------------------
// Takes one event request per cycle when the output is not stalled and
// returns exactly one result per event. An accepted request is held in an
// input register; while it is held there, the state update and the result are
// computed, and both are stored together when the result register advances.
// The election state is read, updated and written back for each request,
// which sustains one request per cycle. The replica id is written on the cfg
// port, which is always ready; write it only while no request is in flight.
`default_nettype none

module raft_election_state
  import raft_es_pkg::*;
#(
  parameter int MAX_REPLICAS = 16,
  parameter int TERM_BITS    = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [ID_BITS-1:0]    cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MODE_BITS-1:0]  mode,
  input  wire logic [FTERM_BITS-1:0] term_in,
  input  wire logic [ID_BITS-1:0]    peer,
  input  wire logic                  peer_present,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [ROLE_BITS-1:0]  role,
  output logic      [FTERM_BITS-1:0] term_out,
  output logic                       vote_held,
  output logic      [ID_BITS-1:0]    vote_target,
  output logic      [CNT_BITS-1:0]   votes_granted,
  output logic                       ok,
  output logic                       fault
);

  localparam int VW = (MAX_REPLICAS < (1 << ID_BITS)) ? MAX_REPLICAS : (1 << ID_BITS);

  logic [ID_BITS-1:0]    self_id;

  logic                  s1_valid;
  logic [MODE_BITS-1:0]  s1_mode;
  logic [FTERM_BITS-1:0] s1_term;
  logic [ID_BITS-1:0]    s1_peer;
  logic                  s1_present;

  logic [ROLE_BITS-1:0]  role_reg;
  logic [TERM_BITS-1:0]  term_reg;
  logic                  vote_valid;
  logic [ID_BITS-1:0]    vote_id;
  logic [VW-1:0]         voter_bits;
  logic [CNT_BITS-1:0]   voter_cnt;

  logic [ROLE_BITS-1:0]  role_next;
  logic [TERM_BITS-1:0]  term_next;
  logic                  vote_valid_next;
  logic [ID_BITS-1:0]    vote_id_next;
  logic [VW-1:0]         voter_bits_next;
  logic [CNT_BITS-1:0]   voter_cnt_next;
  res_t                  res_next;
  res_t                  res;

  logic                  advance;
  logic                  accept;
  logic                  fire;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign fire      = s1_valid && advance;

  raft_es_update #(
    .MAX_REPLICAS (MAX_REPLICAS),
    .TERM_BITS    (TERM_BITS)
  ) u_update (
    .mode         (s1_mode),
    .term_in      (s1_term),
    .peer         (s1_peer),
    .peer_present (s1_present),
    .self_id      (self_id),
    .role_cur     (role_reg),
    .term_cur     (term_reg),
    .vv_cur       (vote_valid),
    .vid_cur      (vote_id),
    .bits_cur     (voter_bits),
    .cnt_cur      (voter_cnt),
    .role_next    (role_next),
    .term_next    (term_next),
    .vv_next      (vote_valid_next),
    .vid_next     (vote_id_next),
    .bits_next    (voter_bits_next),
    .cnt_next     (voter_cnt_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      self_id <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode    <= mode;
      s1_term    <= term_in;
      s1_peer    <= peer;
      s1_present <= peer_present;
    end
  end

  // election state
  always_ff @(posedge clk) begin
    if (rst) begin
      role_reg   <= ROLE_FOLLOWER;
      term_reg   <= '0;
      vote_valid <= 1'b0;
      vote_id    <= '0;
      voter_bits <= '0;
      voter_cnt  <= '0;
    end else if (fire) begin
      role_reg   <= role_next;
      term_reg   <= term_next;
      vote_valid <= vote_valid_next;
      vote_id    <= vote_id_next;
      voter_bits <= voter_bits_next;
      voter_cnt  <= voter_cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign role          = res.role;
  assign term_out      = res.term;
  assign vote_held     = res.vote_held;
  assign vote_target   = res.vote_target;
  assign votes_granted = res.votes_granted;
  assign ok            = res.ok;
  assign fault         = res.fault;

endmodule

`default_nettype wire
